/* design/aebm_pkg.sv */
// ----------------------------------------------------------------------------
// aebm_pkg
// Shared constants, types and elaboration-time helpers of the energy meter.
// ----------------------------------------------------------------------------
package aebm_pkg;

  localparam int unsigned SAMPLES_PER_GROUP = 40;   // 1..64
  localparam int unsigned RING_DEPTH        = 512;  // 2..4096

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BEAM_W   = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned SUM_W    = 37;
  localparam int unsigned SQUARE_W = 31;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned FLOOR_W  = 8;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(-90);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // ring slot wrap: index is kept in INDEX_W bits even for deeper rings
  localparam int unsigned RING_WRAP =
      (RING_DEPTH < (1 << INDEX_W)) ? RING_DEPTH - 1 : (1 << INDEX_W) - 1;

  // 10*log10(2) in Q.24
  localparam logic [25:0] DB_PER_OCTAVE_Q24 = 26'd50504453;

  localparam int unsigned LG_W  = 22;  // log2 in Q.16, integer part up to 36
  localparam int unsigned NEG_W = 24;

  localparam logic [SUM_W-1:0] LOUD_SUM = SUM_W'(SAMPLES_PER_GROUP) << 30;

  // log2 in Q.16 by repeated squaring, used only on constants
  function automatic longint unsigned lg_const(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned frac;
    p = 63;
    frac = 0;
    while (p > 0 && ((x >> p) & 1) == 0) p--;
    if (p >= 30) m = x >> (p - 30);
    else m = x << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  localparam longint unsigned NL_BASE_L = 30 * 65536 + lg_const(SAMPLES_PER_GROUP);
  localparam logic [LG_W-1:0] NL_BASE = NL_BASE_L[LG_W-1:0];

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [INDEX_W-1:0] ring_index;
    logic [BEAM_W-1:0]  angle;
    logic [BEAM_W-1:0]  confidence;
  } group_t;

endpackage

/* design/audio_block_energy_meter_core.sv */
// ----------------------------------------------------------------------------
// audio_block_energy_meter_core
// Mean-square energy meter: groups of squared samples to a Q0.16 dB level.
// ----------------------------------------------------------------------------
// Input: one sample a cycle while full is low; the front end holds a closing
// sample while the queue is full, and the level unit handles one group at a time.
// Silent or full-scale groups skip straight to the result; groups below the
// floor skip the divide; others go through normalize, 16 squaring steps and
// 24 divide steps in the level unit.
// Reset (rst, synchronous): clears sum, count, ring index and queue; floor -90 dB.
module audio_block_energy_meter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [aebm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [aebm_pkg::BEAM_W-1:0]   beam_angle,
  input  logic [aebm_pkg::BEAM_W-1:0]          beam_confidence,
  input  logic                                 cfg_write,
  input  logic [aebm_pkg::FLOOR_W-1:0]         cfg_data,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [aebm_pkg::LEVEL_W-1:0]         energy_level,
  output logic [aebm_pkg::INDEX_W-1:0]         ring_index,
  output logic signed [aebm_pkg::BEAM_W-1:0]   angle_out,
  output logic [aebm_pkg::BEAM_W-1:0]          confidence_out
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  aebm_pkg::group_t q_wdata;
  aebm_pkg::group_t q_rdata;

  aebm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .sample          (sample),
    .beam_angle      (beam_angle),
    .beam_confidence (beam_confidence),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  aebm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  aebm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .q_data         (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .energy_level   (energy_level),
    .ring_index     (ring_index),
    .angle_out      (angle_out),
    .confidence_out (confidence_out)
  );

endmodule

/* design/aebm_front.sv */
// ----------------------------------------------------------------------------
// aebm_front
// Squares samples, accumulates them and closes a group every N samples.
// ----------------------------------------------------------------------------
module aebm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic signed [aebm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [aebm_pkg::BEAM_W-1:0]   beam_angle,
  input  logic [aebm_pkg::BEAM_W-1:0]          beam_confidence,
  output logic                             q_push,
  output aebm_pkg::group_t                 q_data,
  input  logic                             q_full
);

  logic                             s1_valid;
  logic [aebm_pkg::SQUARE_W-1:0]    s1_square;
  logic [aebm_pkg::BEAM_W-1:0]      s1_angle;
  logic [aebm_pkg::BEAM_W-1:0]      s1_conf;
  logic [aebm_pkg::SUM_W-1:0]       sum;
  logic [aebm_pkg::COUNT_W-1:0]     count;
  logic [aebm_pkg::INDEX_W-1:0]     write_index;

  logic                             s1_close;
  logic                             stall;
  logic                             accept;
  logic                             advance;
  logic signed [aebm_pkg::SAMPLE_W:0] sample_ext;
  logic [aebm_pkg::SAMPLE_W-1:0]    mag;
  logic [2*aebm_pkg::SAMPLE_W-1:0]  mag_sq;
  logic [aebm_pkg::SUM_W-1:0]       sum_next;
  logic [aebm_pkg::INDEX_W-1:0]     index_next;

  assign sample_ext = {sample[aebm_pkg::SAMPLE_W-1], sample};
  assign mag        = sample_ext[aebm_pkg::SAMPLE_W]
                      ? aebm_pkg::SAMPLE_W'(-sample_ext)
                      : sample_ext[aebm_pkg::SAMPLE_W-1:0];
  assign mag_sq     = mag * mag;

  assign s1_close = (count == aebm_pkg::COUNT_W'(aebm_pkg::SAMPLES_PER_GROUP - 1));
  assign stall    = s1_valid && s1_close && q_full;
  assign full     = stall;
  assign accept   = push && !full;
  assign advance  = s1_valid && !stall;

  assign sum_next   = sum + aebm_pkg::SUM_W'(s1_square);
  assign index_next = (write_index == aebm_pkg::INDEX_W'(aebm_pkg::RING_WRAP))
                      ? '0 : write_index + 1'b1;

  assign q_push          = advance && s1_close;
  assign q_data.sum        = sum_next;
  assign q_data.ring_index = write_index;
  assign q_data.angle      = s1_angle;
  assign q_data.confidence = s1_conf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      sum         <= '0;
      count       <= '0;
      write_index <= '0;
    end else begin
      if (!stall) begin
        s1_valid <= accept;
      end
      if (advance) begin
        if (s1_close) begin
          sum         <= '0;
          count       <= '0;
          write_index <= index_next;
        end else begin
          sum   <= sum_next;
          count <= count + 1'b1;
        end
      end
    end
    if (accept) begin
      s1_square <= mag_sq[aebm_pkg::SQUARE_W-1:0];
      s1_angle  <= beam_angle;
      s1_conf   <= beam_confidence;
    end
  end

endmodule

/* design/aebm_queue.sv */
// ----------------------------------------------------------------------------
// aebm_queue
// Short FIFO of closed groups between accumulator and level unit.
// ----------------------------------------------------------------------------
module aebm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  aebm_pkg::group_t wdata,
  output logic             full,
  input  logic             pop,
  output aebm_pkg::group_t rdata,
  output logic             empty
);

  localparam int unsigned CNT_W = $clog2(aebm_pkg::QUEUE_DEPTH + 1);

  aebm_pkg::group_t                entries [aebm_pkg::QUEUE_DEPTH];
  logic [aebm_pkg::QPTR_W-1:0]     wp;
  logic [aebm_pkg::QPTR_W-1:0]     rp;
  logic [CNT_W-1:0]                fill;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (fill == CNT_W'(aebm_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == aebm_pkg::QPTR_W'(aebm_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == aebm_pkg::QPTR_W'(aebm_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
    if (do_push) begin
      entries[wp] <= wdata;
    end
  end

endmodule

/* design/aebm_back.sv */
// ----------------------------------------------------------------------------
// aebm_back
// Per-group level unit: log2 by squaring, dB scale, divide by floor.
// ----------------------------------------------------------------------------
module aebm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [aebm_pkg::FLOOR_W-1:0]    cfg_data,
  input  aebm_pkg::group_t                q_data,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [aebm_pkg::LEVEL_W-1:0]    energy_level,
  output logic [aebm_pkg::INDEX_W-1:0]    ring_index,
  output logic signed [aebm_pkg::BEAM_W-1:0] angle_out,
  output logic [aebm_pkg::BEAM_W-1:0]     confidence_out
);

  localparam int unsigned STEP_W    = 5;
  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned NUM_W     = aebm_pkg::NEG_W;
  localparam int unsigned P_W       = 6;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_LOG, S_NL, S_SCALE, S_NUM, S_DIV, S_DONE
  } state_t;

  state_t                            state;
  logic [aebm_pkg::FLOOR_W-1:0]      floor_db;
  logic                              out_valid;
  logic [aebm_pkg::SUM_W-1:0]        x;
  logic [P_W-1:0]                    p;
  logic [30:0]                       mant;
  logic [15:0]                       frac;
  logic [STEP_W-1:0]                 step;
  logic [aebm_pkg::LG_W-1:0]         nl;
  logic [aebm_pkg::NEG_W-1:0]        negdb;
  logic [NUM_W-1:0]                  dividend;
  logic [aebm_pkg::FLOOR_W-1:0]      rem;
  logic [NUM_W-1:0]                  quo;
  logic [aebm_pkg::LEVEL_W-1:0]      level;
  logic [aebm_pkg::INDEX_W-1:0]      g_index;
  logic [aebm_pkg::BEAM_W-1:0]       g_angle;
  logic [aebm_pkg::BEAM_W-1:0]       g_conf;

  logic [aebm_pkg::FLOOR_W-1:0]      f_div;
  logic [61:0]                       m_sq;
  logic [31:0]                       m_sh;
  logic signed [aebm_pkg::LG_W+2:0]  nl_s;
  logic [47:0]                       scale_prod;
  logic signed [NUM_W:0]             num_s;
  logic [aebm_pkg::FLOOR_W:0]        trial;
  logic                              trial_ge;
  logic [NUM_W-1:0]                  quo_next;
  logic                              load_out;

  // non-negative floor acts as -1 dB
  assign f_div = floor_db[aebm_pkg::FLOOR_W-1] ? aebm_pkg::FLOOR_W'(-floor_db)
                                                : aebm_pkg::FLOOR_W'(1);

  assign m_sq = mant * mant;
  assign m_sh = m_sq[61:30];

  assign nl_s = $signed({3'b000, aebm_pkg::NL_BASE}) - $signed({3'b000, p, frac});
  assign scale_prod = nl * aebm_pkg::DB_PER_OCTAVE_Q24;
  assign num_s = $signed({1'b0, f_div, 16'h0000}) - $signed({1'b0, negdb});

  assign trial    = {rem, dividend[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, f_div});
  assign quo_next = {quo[NUM_W-2:0], trial_ge};

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign load_out = (state == S_DONE) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      floor_db  <= aebm_pkg::FLOOR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        floor_db <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            x       <= q_data.sum;
            p       <= P_W'(aebm_pkg::SUM_W - 1);
            g_index <= q_data.ring_index;
            g_angle <= q_data.angle;
            g_conf  <= q_data.confidence;
            if (q_data.sum == '0) begin
              level <= '0;
              state <= S_DONE;
            end else if (q_data.sum >= aebm_pkg::LOUD_SUM) begin
              level <= '1;
              state <= S_DONE;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          // one bit a cycle until the top set bit sits at the MSB
          if (x[aebm_pkg::SUM_W-1]) begin
            mant  <= x[aebm_pkg::SUM_W-1 -: 31];
            frac  <= '0;
            step  <= '0;
            state <= S_LOG;
          end else begin
            x <= {x[aebm_pkg::SUM_W-2:0], 1'b0};
            p <= p - 1'b1;
          end
        end
        S_LOG: begin
          if (m_sh[31]) begin
            mant <= m_sh[31:1];
          end else begin
            mant <= m_sh[30:0];
          end
          frac <= {frac[14:0], m_sh[31]};
          step <= step + 1'b1;
          if (step == STEP_W'(LOG_STEPS - 1)) begin
            state <= S_NL;
          end
        end
        S_NL: begin
          nl    <= nl_s[aebm_pkg::LG_W+2] ? '0 : nl_s[aebm_pkg::LG_W-1:0];
          state <= S_SCALE;
        end
        S_SCALE: begin
          negdb <= scale_prod[24 +: aebm_pkg::NEG_W];
          state <= S_NUM;
        end
        S_NUM: begin
          if (num_s <= 0) begin
            level <= '0;
            state <= S_DONE;
          end else begin
            dividend <= num_s[NUM_W-1:0];
            rem      <= '0;
            quo      <= '0;
            step     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem      <= trial_ge ? aebm_pkg::FLOOR_W'(trial - {1'b0, f_div})
                               : trial[aebm_pkg::FLOOR_W-1:0];
          quo      <= quo_next;
          dividend <= {dividend[NUM_W-2:0], 1'b0};
          step     <= step + 1'b1;
          if (step == STEP_W'(NUM_W - 1)) begin
            level <= (quo_next > NUM_W'(16'hFFFF)) ? '1
                                                    : quo_next[aebm_pkg::LEVEL_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            energy_level   <= level;
            ring_index     <= g_index;
            angle_out      <= g_angle;
            confidence_out <= g_conf;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> (x != '0))
    else $error("normalize loop entered with zero sum");

  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOG) |-> mant[30])
    else $error("log mantissa left [1,2)");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < f_div))
    else $error("divider remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop && state == S_DONE) |=> (state == S_DONE))
    else $error("result register overwritten while held");

endmodule
